### rtl/core/tbpf_pkg.sv
// Shared types, widths and helpers for the temporal biquad pixel filter.
// No dependencies; imported by every module of the block.
package tbpf_pkg;

   localparam int ELEMENTS     = 16384;
   localparam int POS_W        = $clog2(ELEMENTS);
   localparam int LEN_W        = 15;
   localparam int PIXEL_W      = 8;
   localparam int GAIN_W       = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int FRAC_BITS    = 8;

   localparam int FB_PROD_W    = GAIN_W + PIXEL_W + 1;
   localparam int FB_SUM_W     = FB_PROD_W + 2;
   localparam int MID_W        = FB_SUM_W - FRAC_BITS;
   localparam int FW_MID_W     = GAIN_W + MID_W;
   localparam int FW_SUM_W     = FW_MID_W + 2;
   localparam int ACC_W        = FW_SUM_W - FRAC_BITS;

   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_LEVEL_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [PIXEL_W-1:0]            pixel_type;
   typedef logic signed [GAIN_W-1:0]      gain_type;
   typedef logic [POS_W-1:0]              pos_type;
   typedef logic [LEN_W-1:0]              len_type;
   typedef logic [CSR_INDEX_W-1:0]        csr_index_type;
   typedef logic [CSR_DATA_W-1:0]         csr_data_type;
   typedef logic [FIFO_LEVEL_W-1:0]       fifo_level_type;

   typedef struct packed {
      pixel_type last;
      pixel_type prev;
   } state_type;

   typedef struct packed {
      logic           not_empty;
      fifo_level_type level;
   } rsp_fifo_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FB_CURRENT     = 3'd0,
      CSR_FB_LAST        = 3'd1,
      CSR_FB_PREV        = 3'd2,
      CSR_FW_MID         = 3'd3,
      CSR_FW_LAST        = 3'd4,
      CSR_FW_PREV        = 3'd5,
      CSR_FRAME_ELEMENTS = 3'd6
   } csr_reg_type;

   // saturate a signed value to the 0..255 pixel range
   function automatic pixel_type clamp_pixel(input logic signed [ACC_W-1:0] value);
      pixel_type result;
      if (value < 0) begin
         result = '0;
      end else if (value > ACC_W'(signed'(32'(2 ** PIXEL_W - 1)))) begin
         result = '1;
      end else begin
         result = value[PIXEL_W-1:0];
      end
      return result;
   endfunction

endpackage

### rtl/core/tbpf_rsp_fifo.sv
// Result queue of the temporal biquad pixel filter: holds finished words until taken.
// Depends on tbpf_pkg for depth, widths and the status struct.
module tbpf_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tbpf_pkg::pixel_type          push_data,
   input  logic                         pop,
   output tbpf_pkg::pixel_type          head_data,
   output tbpf_pkg::rsp_fifo_status_type status
);
   import tbpf_pkg::*;

   pixel_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]    wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]    rd_ptr_in;
   fifo_level_type           level_ff;
   fifo_level_type           level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = slot_ff[rd_ptr_ff];
   assign status.not_empty = (level_ff != '0);
   assign status.level     = level_ff;

endmodule

### rtl/core/temporal_biquad_pixel_filter.sv
// Temporal biquad pixel filter: takes one word per clock while req_ready is high and
// delivers one filtered word per input. Both frame states of every position sit in
// one 16384 x 16 synchronous store, read when a word is accepted and written back
// from stage 2; a word that hits the position written in that same cycle takes the
// new state directly. A word whose position equals that of the word accepted just
// before (a one-element frame, or repeated frame-first marks) waits until that word
// has left stage 1. Up to 8 words may be in flight or queued, so a stalled result
// side stops the input once 8 words are outstanding, counting those still in the
// pipe. The store reads as zero after reset through a fill count of written
// positions, so there is no clearing pass. Depends on tbpf_pkg and tbpf_rsp_fifo.
module temporal_biquad_pixel_filter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tbpf_pkg::pixel_type     req_pixel_in,
   input  logic                    req_frame_first,
   input  logic                    req_seed,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tbpf_pkg::pixel_type     rsp_pixel_out,
   input  logic                    csr_write_en,
   input  tbpf_pkg::csr_index_type csr_index,
   input  tbpf_pkg::csr_data_type  csr_write_data
);
   import tbpf_pkg::*;

   // configuration
   gain_type fb_cur_ff, fb_cur_in;
   gain_type fb_last_ff, fb_last_in;
   gain_type fb_prev_ff, fb_prev_in;
   gain_type fw_mid_ff, fw_mid_in;
   gain_type fw_last_ff, fw_last_in;
   gain_type fw_prev_ff, fw_prev_in;
   len_type  frame_elements_ff, frame_elements_in;

   // position tracking
   pos_type        position_ff, position_in;
   len_type        fill_ff, fill_in;
   fifo_level_type outstanding_ff, outstanding_in;
   len_type        len_eff;
   pos_type        pos_raw;
   pos_type        acc_pos;
   len_type        pos_next;
   logic           hazard;
   logic           req_accept;
   logic           rsp_accept;
   logic           fwd_hit;

   // state store
   state_type      store_mem [ELEMENTS];
   state_type      store_rd_ff;
   state_type      wr_entry;

   // stage 1: state select, feedback products
   logic           s1_valid_ff;
   pos_type        s1_pos_ff;
   pixel_type      s1_pix_ff;
   logic           s1_seed_ff;
   logic           s1_hit_ff;
   logic           s1_filled_ff;
   state_type      s1_fwd_ff;
   state_type      s1_state;
   logic signed [FB_PROD_W-1:0] s1_p0, s1_p1, s1_p2;

   // stage 2: feedback sum, write-back
   logic           s2_valid_ff;
   pos_type        s2_pos_ff;
   pixel_type      s2_last_ff;
   pixel_type      s2_prev_ff;
   logic signed [FB_PROD_W-1:0] s2_p0_ff, s2_p1_ff, s2_p2_ff;
   logic signed [FB_SUM_W-1:0]  s2_sum;
   logic signed [MID_W-1:0]     s2_mid;
   pixel_type      s2_mid_clamp;

   // stage 3: forward products
   logic           s3_valid_ff;
   logic signed [MID_W-1:0]     s3_mid_ff;
   pixel_type      s3_last_ff;
   pixel_type      s3_prev_ff;
   logic signed [FW_MID_W-1:0]  s3_q0;
   logic signed [FB_PROD_W-1:0] s3_q1, s3_q2;

   // stage 4: forward sum, clamp
   logic           s4_valid_ff;
   logic signed [FW_MID_W-1:0]  s4_q0_ff;
   logic signed [FB_PROD_W-1:0] s4_q1_ff, s4_q2_ff;
   logic signed [FW_SUM_W-1:0]  s4_sum;
   logic signed [ACC_W-1:0]     s4_acc;
   pixel_type      s4_pixel;

   rsp_fifo_status_type fifo_status;

   // configuration writes
   always_comb begin
      fb_cur_in         = fb_cur_ff;
      fb_last_in        = fb_last_ff;
      fb_prev_in        = fb_prev_ff;
      fw_mid_in         = fw_mid_ff;
      fw_last_in        = fw_last_ff;
      fw_prev_in        = fw_prev_ff;
      frame_elements_in = frame_elements_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FB_CURRENT:     fb_cur_in = gain_type'(csr_write_data);
            CSR_FB_LAST:        fb_last_in = gain_type'(csr_write_data);
            CSR_FB_PREV:        fb_prev_in = gain_type'(csr_write_data);
            CSR_FW_MID:         fw_mid_in = gain_type'(csr_write_data);
            CSR_FW_LAST:        fw_last_in = gain_type'(csr_write_data);
            CSR_FW_PREV:        fw_prev_in = gain_type'(csr_write_data);
            CSR_FRAME_ELEMENTS: frame_elements_in = csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_cur_ff         <= '0;
         fb_last_ff        <= '0;
         fb_prev_ff        <= '0;
         fw_mid_ff         <= '0;
         fw_last_ff        <= '0;
         fw_prev_ff        <= '0;
         frame_elements_ff <= LEN_W'(ELEMENTS);
      end else begin
         fb_cur_ff         <= fb_cur_in;
         fb_last_ff        <= fb_last_in;
         fb_prev_ff        <= fb_prev_in;
         fw_mid_ff         <= fw_mid_in;
         fw_last_ff        <= fw_last_in;
         fw_prev_ff        <= fw_prev_in;
         frame_elements_ff <= frame_elements_in;
      end
   end

   // position, fill count and credit
   always_comb begin
      len_eff = (frame_elements_ff == '0 || frame_elements_ff > LEN_W'(ELEMENTS))
                ? LEN_W'(ELEMENTS) : frame_elements_ff;
      pos_raw = req_frame_first ? '0 : position_ff;
      acc_pos = (len_type'(pos_raw) >= len_eff) ? '0 : pos_raw;
      pos_next = len_type'(acc_pos) + len_type'(1);
      hazard  = s1_valid_ff && (s1_pos_ff == acc_pos);
      fwd_hit = s2_valid_ff && (s2_pos_ff == acc_pos);
   end

   assign req_ready  = !reset && (outstanding_ff < FIFO_LEVEL_W'(FIFO_DEPTH)) && !hazard;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = fifo_status.not_empty;
   assign rsp_accept = rsp_valid && rsp_ready;

   always_comb begin
      position_in    = position_ff;
      fill_in        = fill_ff;
      outstanding_in = outstanding_ff;
      if (req_accept) begin
         position_in = (pos_next >= len_eff) ? '0 : pos_next[POS_W-1:0];
         if (len_type'(acc_pos) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (req_accept && !rsp_accept) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_accept && !req_accept) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         fill_ff        <= '0;
         outstanding_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
      end else begin
         position_ff    <= position_in;
         fill_ff        <= fill_in;
         outstanding_ff <= outstanding_in;
         s1_valid_ff    <= req_accept;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
      end
   end

   // store: read on accept, write back from stage 2
   always_ff @(posedge clock) begin
      if (req_accept) begin
         store_rd_ff <= store_mem[acc_pos];
      end
      if (s2_valid_ff) begin
         store_mem[s2_pos_ff] <= wr_entry;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pos_ff    <= acc_pos;
         s1_pix_ff    <= req_pixel_in;
         s1_seed_ff   <= req_seed;
         s1_hit_ff    <= fwd_hit;
         s1_filled_ff <= len_type'(acc_pos) < fill_ff;
         s1_fwd_ff    <= wr_entry;
      end
   end

   always_comb begin
      if (s1_seed_ff) begin
         s1_state.last = s1_pix_ff;
         s1_state.prev = s1_pix_ff;
      end else if (s1_hit_ff) begin
         s1_state = s1_fwd_ff;
      end else if (s1_filled_ff) begin
         s1_state = store_rd_ff;
      end else begin
         s1_state = '0;
      end
      s1_p0 = fb_cur_ff * $signed({1'b0, s1_pix_ff});
      s1_p1 = fb_last_ff * $signed({1'b0, s1_state.last});
      s1_p2 = fb_prev_ff * $signed({1'b0, s1_state.prev});
   end

   // stage 2
   always_ff @(posedge clock) begin
      s2_pos_ff  <= s1_pos_ff;
      s2_last_ff <= s1_state.last;
      s2_prev_ff <= s1_state.prev;
      s2_p0_ff   <= s1_p0;
      s2_p1_ff   <= s1_p1;
      s2_p2_ff   <= s1_p2;
   end

   always_comb begin
      s2_sum        = s2_p0_ff + s2_p1_ff + s2_p2_ff;
      s2_mid        = s2_sum[FB_SUM_W-1:FRAC_BITS];
      s2_mid_clamp  = clamp_pixel(ACC_W'(s2_mid));
      wr_entry.last = s2_mid_clamp;
      wr_entry.prev = s2_last_ff;
   end

   // stage 3
   always_ff @(posedge clock) begin
      s3_mid_ff  <= s2_mid;
      s3_last_ff <= s2_last_ff;
      s3_prev_ff <= s2_prev_ff;
   end

   always_comb begin
      s3_q0 = fw_mid_ff * s3_mid_ff;
      s3_q1 = fw_last_ff * $signed({1'b0, s3_last_ff});
      s3_q2 = fw_prev_ff * $signed({1'b0, s3_prev_ff});
   end

   // stage 4
   always_ff @(posedge clock) begin
      s4_q0_ff <= s3_q0;
      s4_q1_ff <= s3_q1;
      s4_q2_ff <= s3_q2;
   end

   always_comb begin
      s4_sum   = s4_q0_ff + s4_q1_ff + s4_q2_ff;
      s4_acc   = s4_sum[FW_SUM_W-1:FRAC_BITS];
      s4_pixel = clamp_pixel(s4_acc);
   end

   tbpf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_valid_ff),
      .push_data (s4_pixel),
      .pop       (rsp_accept),
      .head_data (rsp_pixel_out),
      .status    (fifo_status)
   );

   // back-to-back words never share a position in stages 1 and 2
   a_no_adjacent_same_pos : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff |-> s1_pos_ff != s2_pos_ff)
      else $error("stages 1 and 2 hold the same position");

   // credit count matches words in the pipe plus words queued
   a_credit_tracks_words : assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == FIFO_LEVEL_W'(s1_valid_ff) + FIFO_LEVEL_W'(s2_valid_ff)
                        + FIFO_LEVEL_W'(s3_valid_ff) + FIFO_LEVEL_W'(s4_valid_ff)
                        + fifo_status.level)
      else $error("credit count out of step");

   // written positions form a prefix that always covers the current position
   a_position_within_fill : assert property (@(posedge clock) disable iff (reset)
      len_type'(position_ff) <= fill_ff)
      else $error("position ahead of fill count");

   // never push into a full queue
   a_no_queue_overflow : assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> fifo_status.level < FIFO_LEVEL_W'(FIFO_DEPTH))
      else $error("result queue overflow");

endmodule

### dv/temporal_biquad_pixel_filter_tb.sv
// Testbench for temporal_biquad_pixel_filter: streams pixel words under changing gain and
// frame-length settings, predicts every filtered word alongside its own frame stores and
// checks results in order. Depends on tbpf_pkg and the filter RTL.
module temporal_biquad_pixel_filter_tb;
   import tbpf_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_LIMIT      = 4000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam csr_index_type CSR_UNUSED = 3'd7;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   pixel_type     req_pixel_in = '0;
   logic          req_frame_first = 1'b0;
   logic          req_seed = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   pixel_type     rsp_pixel_out;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_write_data = '0;

   gain_type  fb_gain_cur, fb_gain_last, fb_gain_prev;
   gain_type  fw_gain_mid, fw_gain_last, fw_gain_prev;
   len_type   frame_len_reg;
   pixel_type last_state [ELEMENTS];
   pixel_type prev_state [ELEMENTS];
   int        frame_pos;

   pixel_type expected_pixels [$];
   int words_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int settings_applied = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int idle_cycles = 0;

   temporal_biquad_pixel_filter u_dut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   function automatic void clear_filter_state();
      fb_gain_cur   = '0;
      fb_gain_last  = '0;
      fb_gain_prev  = '0;
      fw_gain_mid   = '0;
      fw_gain_last  = '0;
      fw_gain_prev  = '0;
      frame_len_reg = len_type'(ELEMENTS);
      frame_pos     = 0;
      foreach (last_state[i]) begin
         last_state[i] = '0;
         prev_state[i] = '0;
      end
   endfunction

   function automatic int active_length();
      if (frame_len_reg == 0 || frame_len_reg > ELEMENTS) return ELEMENTS;
      return int'(frame_len_reg);
   endfunction

   function automatic pixel_type saturate_pixel(input longint v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return pixel_type'(v);
   endfunction

   function automatic pixel_type filter_pixel(input pixel_type px, input logic first,
                                              input logic sd);
      int        len;
      int        pos;
      longint    x, last_v, prev_v, mid, acc;
      pixel_type result;
      len = active_length();
      pos = first ? 0 : frame_pos;
      if (pos >= len) pos = 0;
      x = longint'(px);
      if (sd) begin
         last_v = x;
         prev_v = x;
      end else begin
         last_v = longint'(last_state[pos]);
         prev_v = longint'(prev_state[pos]);
      end
      mid = (longint'(fb_gain_cur) * x + longint'(fb_gain_last) * last_v
             + longint'(fb_gain_prev) * prev_v) >>> FRAC_BITS;
      acc = (longint'(fw_gain_mid) * mid + longint'(fw_gain_last) * last_v
             + longint'(fw_gain_prev) * prev_v) >>> FRAC_BITS;
      result = saturate_pixel(acc);
      prev_state[pos] = pixel_type'(last_v);
      last_state[pos] = saturate_pixel(mid);
      pos++;
      if (pos >= len) pos = 0;
      frame_pos = pos;
      return result;
   endfunction

   function automatic csr_data_type random_gain();
      if ($urandom_range(99) < 75) return csr_data_type'(int'($urandom_range(768)) - 384);
      return csr_data_type'($urandom_range(16'hFFFF));
   endfunction

   function automatic csr_data_type random_length();
      int pick;
      pick = int'($urandom_range(99));
      if (pick < 70) return csr_data_type'($urandom_range(24, 1));
      if (pick < 85) return csr_data_type'($urandom_range(ELEMENTS, 25));
      if (pick < 95) return csr_data_type'($urandom_range(16'h7FFF, ELEMENTS + 1));
      return csr_data_type'($urandom_range(16'hFFFF));
   endfunction

   task automatic write_reg(input csr_index_type idx, input csr_data_type data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_FB_CURRENT:     fb_gain_cur   = gain_type'(data);
         CSR_FB_LAST:        fb_gain_last  = gain_type'(data);
         CSR_FB_PREV:        fb_gain_prev  = gain_type'(data);
         CSR_FW_MID:         fw_gain_mid   = gain_type'(data);
         CSR_FW_LAST:        fw_gain_last  = gain_type'(data);
         CSR_FW_PREV:        fw_gain_prev  = gain_type'(data);
         CSR_FRAME_ELEMENTS: frame_len_reg = data[LEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input csr_data_type b0, input csr_data_type b1,
                                input csr_data_type b2, input csr_data_type f1,
                                input csr_data_type f2, input csr_data_type f3,
                                input csr_data_type len);
      write_reg(CSR_FB_CURRENT, b0);
      write_reg(CSR_FB_LAST, b1);
      write_reg(CSR_FB_PREV, b2);
      write_reg(CSR_FW_MID, f1);
      write_reg(CSR_FW_LAST, f2);
      write_reg(CSR_FW_PREV, f3);
      write_reg(CSR_FRAME_ELEMENTS, len);
      settings_applied++;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_word(input pixel_type px, input logic first, input logic sd);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_in    <= px;
      req_frame_first <= first;
      req_seed        <= sd;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(filter_pixel(px, first, sd));
      words_sent++;
   endtask

   task automatic run_random_stream(input int count);
      int   sent;
      int   run;
      logic seed_frame;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            run = (active_length() < count - sent) ? active_length() : count - sent;
            seed_frame = ($urandom_range(99) < 15);
            for (int i = 0; i < run; i++)
               send_word(pixel_type'($urandom_range(255)), i == 0,
                         seed_frame || ($urandom_range(99) < 3));
            sent += run;
         end else begin
            send_word(pixel_type'($urandom_range(255)), $urandom_range(99) < 30,
                      $urandom_range(99) < 30);
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_word(8'd255, 1'b1, 1'b0);
      send_word(8'd0, 1'b0, 1'b0);
      send_word(8'd255, 1'b0, 1'b1);
   endtask

   task automatic test_gain_extremes();
      settle();
      apply_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd4);
      send_word(8'd255, 1'b1, 1'b0);
      send_word(8'd0, 1'b0, 1'b0);
      send_word(8'd255, 1'b0, 1'b1);
      send_word(8'd0, 1'b0, 1'b1);
   endtask

   // negative mid is stored as zero but feeds the output unclamped
   task automatic test_negative_feedback();
      settle();
      apply_setting(16'hFF00, 16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0000, 16'd4);
      send_word(8'd200, 1'b1, 1'b0);
      send_word(8'd17, 1'b0, 1'b0);
   endtask

   task automatic test_frame_lengths();
      settle();
      apply_setting(16'h0080, 16'h0040, 16'h0040, 16'h0100, 16'h0000, 16'h0040, 16'd0);
      send_word(8'd99, 1'b1, 1'b0);
      settle();
      write_reg(CSR_FRAME_ELEMENTS, 16'hFFFF);
      send_word(8'd5, 1'b0, 1'b0);
      settle();
      write_reg(CSR_FRAME_ELEMENTS, 16'd1);
      send_word(8'd10, 1'b1, 1'b0);
      send_word(8'd20, 1'b1, 1'b0);
      send_word(8'd30, 1'b0, 1'b0);
      settle();
      write_reg(CSR_FRAME_ELEMENTS, 16'd8);
      send_word(8'd1, 1'b1, 1'b0);
      for (int i = 0; i < 4; i++) send_word(pixel_type'(40 * i + 3), 1'b0, 1'b0);
      settle();
      write_reg(CSR_FRAME_ELEMENTS, 16'd3);
      send_word(8'd128, 1'b0, 1'b0);
      send_word(8'd64, 1'b0, 1'b0);
   endtask

   task automatic test_unknown_index();
      settle();
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_word(8'd77, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int count);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < 3; k++) begin
         settle();
         apply_setting(random_gain(), random_gain(), random_gain(), random_gain(),
                       random_gain(), random_gain(), random_length());
         run_random_stream(count / 3);
      end
   endtask

   // hold the result side off while words keep coming, so the input backs up
   task automatic test_backpressure();
      settle();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      apply_setting(16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'd16);
      hold_requests++;
      for (int i = 0; i < 48; i++)
         send_word(pixel_type'($urandom_range(255)), i % 16 == 0, 1'b0);
   endtask

   always @(posedge clock) begin : rsp_side
      pixel_type wanted;
      int        hold_seen;
      int        hold_left;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel_out, expected none, actual %0d",
                     $time, rsp_pixel_out);
            mismatches++;
         end else begin
            wanted = expected_pixels.pop_front();
            if (rsp_pixel_out !== wanted) begin
               $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                        $time, wanted, rsp_pixel_out);
               mismatches++;
            end
            results_checked++;
         end
      end
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clear_filter_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_gain_extremes();
      test_negative_feedback();
      test_frame_lengths();
      test_unknown_index();
      test_random_traffic(0, 0, 225);
      test_random_traffic(57, 0, 225);
      test_random_traffic(0, 57, 225);
      test_random_traffic(13, 13, 225);
      test_backpressure();
      settle();
      $display("summary: %0d words sent, %0d results checked, %0d gain/length settings,",
               words_sent, results_checked, settings_applied);
      $display("summary: %0d mismatches over idle, stall and backpressure phases",
               mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tbpf_pkg.sv
rtl/core/tbpf_rsp_fifo.sv
rtl/core/temporal_biquad_pixel_filter.sv
dv/temporal_biquad_pixel_filter_tb.sv
